// ===== src/pbg_pkg.sv =====
package pbg_pkg;

  // channel count follows the per-channel ports of the top level
  localparam int CHANNELS = 6;

  localparam int LEVEL_W = 3;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LV_0V  = 3'd0;
  localparam level_t LV_10V = 3'd1;
  localparam level_t LV_9V  = 3'd2;
  localparam level_t LV_8V  = 3'd3;
  localparam level_t LV_0V1 = 3'd4;
  localparam level_t LV_0V2 = 3'd5;
  localparam level_t LV_0V5 = 3'd6;

  // mode code is {skip_enable, add_enable}
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE = 2'b00;
  localparam mode_t MODE_ADD  = 2'b01;
  localparam mode_t MODE_SKIP = 2'b10;
  localparam mode_t MODE_BOTH = 2'b11;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SKIP_IDX = cfg_idx_t'(CHANNELS);
  localparam cfg_idx_t CFG_ADD_IDX  = cfg_idx_t'(CHANNELS + 1);

  typedef struct packed {
    logic  fire;
    mode_t mode;
    logic  clk_level;
    logic  clk_rise;
  } lane_ctrl_t;

endpackage

// ===== src/pbg_lane.sv =====
module pbg_lane #(
  parameter int RAND_BITS  = 16,
  parameter bit RESET_PASS = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbg_pkg::lane_ctrl_t  ctrl,
  input  logic                 gate,
  input  logic [RAND_BITS-1:0] rand_val,
  input  logic [RAND_BITS:0]   precision,
  output pbg_pkg::level_t      level
);

  logic last_gate, hide_flag, pass_flag, ghost_flag;
  logic last_gate_next, hide_flag_next, pass_flag_next, ghost_flag_next;
  logic above, below;
  pbg_pkg::level_t ghost_level;

  always_comb begin
    above = {1'b0, rand_val} > precision;
    below = {1'b0, rand_val} < precision;

    ghost_flag_next = ghost_flag;
    // ghost draw on a rising clock while the gate is low
    if (ctrl.clk_rise) begin
      ghost_flag_next = above;
      ghost_level = above ? pbg_pkg::LV_9V : pbg_pkg::LV_0V1;
    end else if (ctrl.clk_level) begin
      ghost_level = ghost_flag ? pbg_pkg::LV_8V : pbg_pkg::LV_0V2;
    end else begin
      ghost_level = pbg_pkg::LV_0V;
    end
  end

  always_comb begin
    last_gate_next = last_gate;
    hide_flag_next = hide_flag;
    pass_flag_next = pass_flag;
    level          = pbg_pkg::LV_0V;
    case (ctrl.mode)
      pbg_pkg::MODE_NONE: begin
        level          = gate ? pbg_pkg::LV_10V : pbg_pkg::LV_0V;
        last_gate_next = gate;
      end
      pbg_pkg::MODE_SKIP: begin
        if (gate && !last_gate) begin
          hide_flag_next = above;
        end
        level          = (gate && !hide_flag_next) ? pbg_pkg::LV_10V : pbg_pkg::LV_0V;
        last_gate_next = gate;
      end
      pbg_pkg::MODE_ADD: begin
        level = gate ? pbg_pkg::LV_10V : ghost_level;
      end
      default: begin
        if (gate) begin
          if (!last_gate) begin
            pass_flag_next = below;
          end
          level = pass_flag_next ? pbg_pkg::LV_10V : pbg_pkg::LV_0V5;
        end else begin
          level = ghost_level;
        end
        last_gate_next = gate;
      end
    endcase
  end

  // ghost only changes in add modes with the gate low
  logic ghost_upd;
  assign ghost_upd = ctrl.mode[0] && !gate;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_gate  <= 1'b0;
      hide_flag  <= 1'b0;
      pass_flag  <= RESET_PASS;
      ghost_flag <= 1'b0;
    end else if (ctrl.fire) begin
      last_gate <= last_gate_next;
      hide_flag <= hide_flag_next;
      pass_flag <= pass_flag_next;
      if (ghost_upd) begin
        ghost_flag <= ghost_flag_next;
      end
    end
  end

endmodule

// ===== src/pbg_merge.sv =====
module pbg_merge (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  pbg_pkg::level_t [pbg_pkg::CHANNELS-1:0]  levels_in,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output pbg_pkg::level_t [pbg_pkg::CHANNELS-1:0]  levels_out
);

  logic take;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      levels_out <= levels_in;
    end
  end

endmodule

// ===== src/probabilistic_trigger_skip_add_top.sv =====
// latency: a beat accepted at one edge shows its level codes at out_valid the next cycle
// throughput: one beat per cycle while the output is not stalled; all six channel lanes
//   evaluate in parallel and a single output register decouples the two sides
// reset (rst, synchronous, active high): output empty, precisions 0.95 of full scale,
//   skip and add enabled, edge memories and flags clear, channel 0 pass flag set
module probabilistic_trigger_skip_add_top #(
  parameter int RAND_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // input sample channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbg_pkg::CHANNELS-1:0]     gate_bits,
  input  logic                             clock_gate,
  input  logic [RAND_BITS-1:0]             rand_ch0,
  input  logic [RAND_BITS-1:0]             rand_ch1,
  input  logic [RAND_BITS-1:0]             rand_ch2,
  input  logic [RAND_BITS-1:0]             rand_ch3,
  input  logic [RAND_BITS-1:0]             rand_ch4,
  input  logic [RAND_BITS-1:0]             rand_ch5,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output pbg_pkg::level_t                  level_ch0,
  output pbg_pkg::level_t                  level_ch1,
  output pbg_pkg::level_t                  level_ch2,
  output pbg_pkg::level_t                  level_ch3,
  output pbg_pkg::level_t                  level_ch4,
  output pbg_pkg::level_t                  level_ch5,
  // register write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  pbg_pkg::cfg_idx_t                cfg_index,
  input  logic [RAND_BITS:0]               cfg_data
);

  // 0.95 of full scale, rounded to nearest
  localparam longint unsigned PREC_RESET_L =
    ((64'd95 << RAND_BITS) + 64'd50) / 64'd100;
  localparam logic [RAND_BITS:0] PREC_RESET = PREC_RESET_L[RAND_BITS:0];

  // configuration registers
  logic [RAND_BITS:0] precision [pbg_pkg::CHANNELS];
  logic               skip_enable;
  logic               add_enable;

  // clock edge memory, shared by all lanes
  logic last_clock;

  logic                                     accept;
  pbg_pkg::lane_ctrl_t                      ctrl;
  logic [RAND_BITS-1:0]                     rand_all [pbg_pkg::CHANNELS];
  pbg_pkg::level_t [pbg_pkg::CHANNELS-1:0]  lane_levels;
  pbg_pkg::level_t [pbg_pkg::CHANNELS-1:0]  out_levels;

  // writes go straight into the registers, so the port never pushes back
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < pbg_pkg::CHANNELS; c++) begin
        precision[c] <= PREC_RESET;
      end
      skip_enable <= 1'b1;
      add_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < pbg_pkg::CFG_SKIP_IDX) begin
        precision[cfg_index] <= cfg_data;
      end else if (cfg_index == pbg_pkg::CFG_SKIP_IDX) begin
        skip_enable <= cfg_data[0];
      end else if (cfg_index == pbg_pkg::CFG_ADD_IDX) begin
        add_enable <= cfg_data[0];
      end
    end
  end

  assign accept = in_valid && !in_stall;

  // common control for the lanes: fire, mode, clock level and clock rising edge
  always_comb begin
    ctrl.fire      = accept;
    ctrl.mode      = {skip_enable, add_enable};
    ctrl.clk_level = clock_gate;
    ctrl.clk_rise  = clock_gate && !last_clock;
  end

  // clock memory only follows the input while add mode is on
  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock <= 1'b0;
    end else if (accept && add_enable) begin
      last_clock <= clock_gate;
    end
  end

  assign rand_all[0] = rand_ch0;
  assign rand_all[1] = rand_ch1;
  assign rand_all[2] = rand_ch2;
  assign rand_all[3] = rand_ch3;
  assign rand_all[4] = rand_ch4;
  assign rand_all[5] = rand_ch5;

  // one lane per channel, each with its own edge and draw flags
  for (genvar c = 0; c < pbg_pkg::CHANNELS; c++) begin : g_lane
    pbg_lane #(
      .RAND_BITS  (RAND_BITS),
      .RESET_PASS (c == 0)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .gate      (gate_bits[c]),
      .rand_val  (rand_all[c]),
      .precision (precision[c]),
      .level     (lane_levels[c])
    );
  end

  // output register collects the lane results into one beat
  pbg_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .levels_in  (lane_levels),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .levels_out (out_levels)
  );

  assign level_ch0 = out_levels[0];
  assign level_ch1 = out_levels[1];
  assign level_ch2 = out_levels[2];
  assign level_ch3 = out_levels[3];
  assign level_ch4 = out_levels[4];
  assign level_ch5 = out_levels[5];

  // input only backs up while a finished beat is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output register free");

  // every accepted beat produces a result the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // level code 7 is never produced
  a_level_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_ch0 != 3'd7 && level_ch1 != 3'd7 && level_ch2 != 3'd7 &&
                   level_ch3 != 3'd7 && level_ch4 != 3'd7 && level_ch5 != 3'd7))
    else $error("illegal level code on output");

  // clock edge memory holds while add mode is off
  a_clock_memory_held: assert property (@(posedge clk) disable iff (rst)
    !add_enable |=> $stable(last_clock))
    else $error("clock memory moved with add mode off");

endmodule

// ===== tb/probabilistic_trigger_skip_add_top_tb.sv =====
`timescale 1ns / 100ps

module probabilistic_trigger_skip_add_top_tb;

  localparam int CHANNELS = pbg_pkg::CHANNELS;
  localparam int LEVEL_W = pbg_pkg::LEVEL_W;
  localparam int RAND_W = 16;
  localparam int PREC_W = RAND_W + 1;
  localparam logic [PREC_W-1:0] PREC_RST = 17'd62259;  // 0.95 of full scale
  localparam int PHASES = 10;
  localparam int PHASE_BEATS = 45;
  localparam int HOLD_CYCLES = 80;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;    // output is one register deep
  localparam int STUCK_LIMIT = 2000;   // cycles with no handshake at all

  typedef logic [CHANNELS-1:0][LEVEL_W-1:0] levels_t;

  // one input beat as the block sees it
  typedef struct packed {
    logic [CHANNELS-1:0]             gates;
    logic                            clock;
    logic [CHANNELS-1:0][RAND_W-1:0] rnd;
  } sample_t;

  // one row of the directed table: a register write or a sample beat
  typedef struct packed {
    logic              is_write;
    pbg_pkg::cfg_idx_t idx;
    logic [PREC_W-1:0] data;
    sample_t           smp;
    logic              known;   // level codes typed in below, not predicted
    levels_t           lv;
  } step_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHANNELS-1:0] gate_bits = '0;
  logic clock_gate = 1'b0;
  logic [RAND_W-1:0] rand_ch0 = '0;
  logic [RAND_W-1:0] rand_ch1 = '0;
  logic [RAND_W-1:0] rand_ch2 = '0;
  logic [RAND_W-1:0] rand_ch3 = '0;
  logic [RAND_W-1:0] rand_ch4 = '0;
  logic [RAND_W-1:0] rand_ch5 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pbg_pkg::level_t level_ch0, level_ch1, level_ch2, level_ch3, level_ch4, level_ch5;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  pbg_pkg::cfg_idx_t cfg_index = '0;
  logic [PREC_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  probabilistic_trigger_skip_add_top #(
    .RAND_BITS(RAND_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .gate_bits(gate_bits),
    .clock_gate(clock_gate),
    .rand_ch0(rand_ch0),
    .rand_ch1(rand_ch1),
    .rand_ch2(rand_ch2),
    .rand_ch3(rand_ch3),
    .rand_ch4(rand_ch4),
    .rand_ch5(rand_ch5),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .level_ch0(level_ch0),
    .level_ch1(level_ch1),
    .level_ch2(level_ch2),
    .level_ch3(level_ch3),
    .level_ch4(level_ch4),
    .level_ch5(level_ch5),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and the per-channel edge state
  // ---------------------------------------------------------------------------
  logic [PREC_W-1:0]   prec_q [CHANNELS] = '{default: PREC_RST};
  logic                skip_on = 1'b1;
  logic                add_on = 1'b1;
  logic [CHANNELS-1:0] gate_seen = '0;
  logic [CHANNELS-1:0] hide_bit = '0;
  logic [CHANNELS-1:0] pass_bit = 6'b000001;  // channel 0 comes out of reset set
  logic [CHANNELS-1:0] ghost_bit = '0;
  logic                clock_seen = 1'b0;

  // levels_t of expected beats, oldest first
  levels_t level_q[$];
  int err_count = 0;
  int beats_out = 0;

  // the beat on the input wires, for the acceptance monitor
  sample_t cur_smp = '0;
  logic    cur_known = 1'b0;
  levels_t cur_lv = '0;

  logic hold_req = 1'b0;  // asks the receiver for one long hold-off

  // gate low: clock edge draws a ghost pulse, held clock keeps its level
  function automatic pbg_pkg::level_t ghost_out(int c, logic rise, logic ck,
                                                logic [PREC_W-1:0] r);
    if (rise) begin
      ghost_bit[c] = (r > prec_q[c]);
      return ghost_bit[c] ? pbg_pkg::LV_9V : pbg_pkg::LV_0V1;
    end
    if (ck)
      return ghost_bit[c] ? pbg_pkg::LV_8V : pbg_pkg::LV_0V2;
    return pbg_pkg::LV_0V;
  endfunction

  function automatic levels_t predict_levels(sample_t s);
    levels_t lv;
    pbg_pkg::mode_t md;
    logic g;
    logic rise;
    logic [PREC_W-1:0] r;
    md = {skip_on, add_on};
    rise = s.clock & ~clock_seen;
    for (int c = 0; c < CHANNELS; c++) begin
      g = s.gates[c];
      r = {1'b0, s.rnd[c]};
      case (md)
        pbg_pkg::MODE_NONE: begin
          lv[c] = g ? pbg_pkg::LV_10V : pbg_pkg::LV_0V;
          gate_seen[c] = g;
        end
        pbg_pkg::MODE_SKIP: begin
          // hide is redrawn on a rising gate only
          if (g && !gate_seen[c])
            hide_bit[c] = (r > prec_q[c]);
          lv[c] = (g && !hide_bit[c]) ? pbg_pkg::LV_10V : pbg_pkg::LV_0V;
          gate_seen[c] = g;
        end
        pbg_pkg::MODE_ADD: begin
          // gate memory is left alone in this mode
          if (g)
            lv[c] = pbg_pkg::LV_10V;
          else
            lv[c] = ghost_out(c, rise, s.clock, r);
        end
        default: begin
          if (g) begin
            if (!gate_seen[c])
              pass_bit[c] = (r < prec_q[c]);
            lv[c] = pass_bit[c] ? pbg_pkg::LV_10V : pbg_pkg::LV_0V5;
          end else begin
            lv[c] = ghost_out(c, rise, s.clock, r);
          end
          gate_seen[c] = g;
        end
      endcase
    end
    // clock memory only moves while add is on
    if (add_on)
      clock_seen = s.clock;
    return lv;
  endfunction

  task automatic report_mismatch(string what);
    if (err_count < 40)
      $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // drivers: everything changes at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_sample(sample_t s, logic known, levels_t lv);
    @(negedge clk);
    in_valid <= 1'b1;
    gate_bits <= s.gates;
    clock_gate <= s.clock;
    rand_ch0 <= s.rnd[0];
    rand_ch1 <= s.rnd[1];
    rand_ch2 <= s.rnd[2];
    rand_ch3 <= s.rnd[3];
    rand_ch4 <= s.rnd[4];
    rand_ch5 <= s.rnd[5];
    cur_smp <= s;
    cur_known <= known;
    cur_lv <= lv;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // drop input valid for a pause set by n (n >= 1)
  task automatic pause(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic wait_idle();
    pause(1);
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pbg_pkg::cfg_idx_t idx, logic [PREC_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == pbg_pkg::CFG_SKIP_IDX)
      skip_on = data[0];
    else if (idx == pbg_pkg::CFG_ADD_IDX)
      add_on = data[0];
    else
      prec_q[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // table helpers: same random fraction and same level on every channel
  function automatic step_t item_row(logic [CHANNELS-1:0] g, logic ck, logic [RAND_W-1:0] r,
                                     logic known, pbg_pkg::level_t lv);
    step_t t;
    t = '0;
    t.smp.gates = g;
    t.smp.clock = ck;
    for (int c = 0; c < CHANNELS; c++) begin
      t.smp.rnd[c] = r;
      t.lv[c] = lv;
    end
    t.known = known;
    return t;
  endfunction

  function automatic step_t write_row(pbg_pkg::cfg_idx_t idx, logic [PREC_W-1:0] d);
    step_t t;
    t = '0;
    t.is_write = 1'b1;
    t.idx = idx;
    t.data = d;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // monitors: sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    levels_t want;
    levels_t got;
    // input beat taken: run the predictor, typed rows still advance its state
    if (in_valid && in_stall === 1'b0) begin
      want = predict_levels(cur_smp);
      level_q.push_back(cur_known ? cur_lv : want);
    end
    // result beat taken: compare against the oldest expectation
    if (out_valid === 1'b1 && !out_stall) begin
      got = {level_ch5, level_ch4, level_ch3, level_ch2, level_ch1, level_ch0};
      if (level_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", beats_out));
      end else begin
        want = level_q.pop_front();
        for (int c = 0; c < CHANNELS; c++)
          if (got[c] !== want[c])
            report_mismatch($sformatf("beat %0d level_ch%0d got %0d want %0d",
                                      beats_out, c, got[c], want[c]));
      end
      beats_out++;
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        stuck = 0;
      else
        stuck++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stretches of different stall density, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall_pct;
    int stretch;
    stall_pct = 0;
    stretch = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        // hold long enough that the output register fills and input stalls
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          stretch = $urandom_range(5, 40);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
        stretch--;
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    step_t plan[$];
    sample_t s;
    logic [CHANNELS-1:0] gates_now;
    logic clock_now;
    logic [PREC_W-1:0] p;
    pbg_pkg::mode_t md;
    int burst_left;
    int v;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, both switches on and 0.95 everywhere after reset
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h3f, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_10V));   // gate rise, pass
    plan.push_back(item_row(6'h00, 1'b1, 16'hffff, 1'b1, pbg_pkg::LV_9V));    // clock rise, ghost
    plan.push_back(item_row(6'h00, 1'b1, 16'h0000, 1'b1, pbg_pkg::LV_8V));    // clock held
    plan.push_back(item_row(6'h3f, 1'b1, 16'hffff, 1'b1, pbg_pkg::LV_0V5));   // gate rise, no pass
    plan.push_back(item_row(6'h3f, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V5));   // held, rand unused
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b1, 16'h0000, 1'b1, pbg_pkg::LV_0V1));   // clock rise, no ghost
    plan.push_back(item_row(6'h15, 1'b0, 16'h1234, 1'b0, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    // precision extremes, including above full scale
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(0), 17'd0));
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(1), 17'd65536));
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(2), 17'h1ffff));
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(3), 17'd65535));
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(4), 17'd1));
    plan.push_back(write_row(pbg_pkg::cfg_idx_t'(5), PREC_RST));
    plan.push_back(item_row(6'h3f, 1'b0, 16'hffff, 1'b0, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b1, 16'hffff, 1'b0, pbg_pkg::LV_0V));
    // add only; upper data bits set, switch bit clear
    plan.push_back(write_row(pbg_pkg::CFG_SKIP_IDX, 17'h1fffe));
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b1, 16'hffff, 1'b0, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h3f, 1'b1, 16'h0000, 1'b1, pbg_pkg::LV_10V));
    // skip only; clock toggles here must not touch the clock memory
    plan.push_back(write_row(pbg_pkg::CFG_SKIP_IDX, 17'd1));
    plan.push_back(write_row(pbg_pkg::CFG_ADD_IDX, 17'd0));
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h3f, 1'b1, 16'hffff, 1'b0, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h3f, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_10V));   // zero never hides
    // plain pass-through
    plan.push_back(write_row(pbg_pkg::CFG_SKIP_IDX, 17'd0));
    plan.push_back(item_row(6'h3f, 1'b0, 16'hffff, 1'b1, pbg_pkg::LV_10V));
    plan.push_back(item_row(6'h00, 1'b1, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    // add back on: clock high is judged against the last add-mode beat
    plan.push_back(write_row(pbg_pkg::CFG_ADD_IDX, 17'd1));
    plan.push_back(item_row(6'h00, 1'b1, 16'h0000, 1'b0, pbg_pkg::LV_0V));
    plan.push_back(item_row(6'h00, 1'b0, 16'h0000, 1'b1, pbg_pkg::LV_0V));
    plan.push_back(write_row(pbg_pkg::CFG_SKIP_IDX, 17'd1));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].smp, plan[i].known, plan[i].lv);
      end
    end

    // random part: each phase picks a mode and fresh precisions
    gates_now = '0;
    clock_now = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      md = pbg_pkg::mode_t'(ph % 4);
      for (int c = 0; c < CHANNELS; c++) begin
        case ($urandom_range(7))
          0: p = 17'd0;
          1: p = 17'd1;
          2: p = 17'd65535;
          3: p = 17'd65536;
          4: p = 17'h1ffff;
          5: p = PREC_RST;
          default: p = PREC_W'($urandom_range(17'h1ffff));
        endcase
        write_reg(pbg_pkg::cfg_idx_t'(c), p);
      end
      write_reg(pbg_pkg::CFG_SKIP_IDX, {16'($urandom), md[1]});
      write_reg(pbg_pkg::CFG_ADD_IDX, {16'($urandom), md[0]});

      burst_left = 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 3 && n == 5)
          hold_req = 1'b1;        // receiver stops while we keep offering
        if (ph == 6 && n == 20)
          wait_idle();            // let everything drain mid-phase
        if (burst_left == 0) begin
          pause($urandom_range(1, 6));
          burst_left = ($urandom_range(4) == 0) ? 60 : $urandom_range(1, 16);
        end

        // mostly edge-rich gate sequences, now and then a random jump
        if ($urandom_range(19) == 0) begin
          gates_now = CHANNELS'($urandom);
        end else begin
          for (int c = 0; c < CHANNELS; c++)
            if ($urandom_range(9) < 4)
              gates_now[c] = ~gates_now[c];
        end
        if ($urandom_range(1) == 1)
          clock_now = ~clock_now;
        s.gates = gates_now;
        s.clock = clock_now;
        // fractions cluster at the extremes and right around the threshold
        for (int c = 0; c < CHANNELS; c++) begin
          case ($urandom_range(5))
            0: v = 0;
            1: v = 16'hffff;
            2, 3: v = int'(prec_q[c]) - 1 + int'($urandom_range(2));
            default: v = int'($urandom_range(16'hffff));
          endcase
          if (v < 0)
            v = 0;
          if (v > 16'hffff)
            v = 16'hffff;
          s.rnd[c] = v[RAND_W-1:0];
        end
        send_sample(s, 1'b0, '0);
        burst_left--;
      end
    end

    wait_idle();
    if (level_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never came", level_q.size()));
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
src/pbg_pkg.sv
src/pbg_lane.sv
src/pbg_merge.sv
src/probabilistic_trigger_skip_add_top.sv
tb/probabilistic_trigger_skip_add_top_tb.sv
